@@ hw/rtl/slc_pkg.sv @@
// Shared types, constants and codes of the status LED blink controller.
package slc_pkg;

    localparam int PIXELS      = 6;
    localparam int IDX_W       = $clog2(PIXELS);
    localparam int CNT_W       = $clog2(PIXELS + 1);
    localparam int STATUS_PIX  = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [23:0] COL_RED    = 24'hFF0000;
    localparam logic [23:0] COL_YELLOW = 24'hFFFF00;
    localparam logic [23:0] COL_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] COL_BLUE   = 24'h0000FF;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_SOLID = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    localparam int PIX_MEMORY   = 0;
    localparam int PIX_SENSORS  = 1;
    localparam int PIX_RELAY    = 2;
    localparam int PIX_BRIDGE   = 3;
    localparam int PIX_NETWORK  = 4;
    localparam int PIX_ACTIVITY = 5;

    localparam logic [2:0] CFG_PIXEL_COUNT  = 3'd0;
    localparam logic [2:0] CFG_BLINK_HALF   = 3'd1;
    localparam logic [2:0] CFG_BURST_HALF   = 3'd2;
    localparam logic [2:0] CFG_TRAFFIC_HOLD = 3'd3;
    localparam logic [2:0] CFG_MEMORY_HOLD  = 3'd4;

    typedef struct packed {
        logic        clear_all;
        logic [7:0]  burst_add;
        logic [23:0] memory_color;
        logic        trigger_memory;
        logic        trigger_network;
        logic        trigger_bridge;
        logic [7:0]  status_word;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic                    act;
        logic [CNT_W-1:0]        count;
        logic [PIXELS-1:0][23:0] colors;
    } frame_t;

endpackage

@@ hw/rtl/slc_front.sv @@
// Front part: accepts service passes, updates panel state and renders frames.
module slc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  slc_pkg::in_item_t in_item,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    output logic              push,
    output slc_pkg::frame_t   push_frame,
    input  logic              queue_full
);

    logic [2:0]  pixel_count_reg;
    logic [15:0] blink_half_reg;
    logic [15:0] burst_half_reg;
    logic [15:0] traffic_hold_reg;
    logic [15:0] memory_hold_reg;

    logic [slc_pkg::PIXELS-1:0][1:0]  mode_reg, mode_next;
    logic [slc_pkg::PIXELS-1:0][23:0] color_reg, color_next;
    logic        phase_reg, phase_next;
    logic [31:0] blink_time_reg, blink_time_next;
    logic [2:0]  pulse_reg, pulse_next;
    logic [2:0][31:0] pulse_time_reg, pulse_time_next;
    logic [23:0] mem_color_reg, mem_color_next;
    logic [7:0]  burst_rem_reg, burst_rem_next;
    logic        burst_lit_reg, burst_lit_next;
    logic [31:0] burst_time_reg, burst_time_next;
    logic [7:0]  prev_status_reg, prev_status_next;

    logic                             accept;
    logic                             refresh;
    logic [slc_pkg::CNT_W-1:0]        frame_len;
    logic [slc_pkg::STATUS_PIX-1:0]   ok;
    logic [slc_pkg::STATUS_PIX-1:0][1:0]  fault_mode;
    logic [slc_pkg::STATUS_PIX-1:0][23:0] fault_color;
    logic [8:0]                       burst_sum;
    logic [31:0]                      hold;
    logic                             any_blink;
    logic [1:0]                       new_mode;
    logic [23:0]                      new_color;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign frame_len = (pixel_count_reg > slc_pkg::CNT_W'(slc_pkg::PIXELS))
                     ? slc_pkg::CNT_W'(slc_pkg::PIXELS)
                     : slc_pkg::CNT_W'(pixel_count_reg);

    assign ok[slc_pkg::PIX_MEMORY]  = (in_item.status_word[1:0] == 2'b11);
    assign ok[slc_pkg::PIX_SENSORS] = (in_item.status_word[3:2] == 2'b11);
    assign ok[slc_pkg::PIX_RELAY]   = in_item.status_word[6];
    assign ok[slc_pkg::PIX_BRIDGE]  = in_item.status_word[7];
    assign ok[slc_pkg::PIX_NETWORK] = (in_item.status_word[5:4] == 2'b11);

    assign fault_mode[slc_pkg::PIX_MEMORY]   = slc_pkg::MODE_SOLID;
    assign fault_mode[slc_pkg::PIX_SENSORS]  = slc_pkg::MODE_BLINK;
    assign fault_mode[slc_pkg::PIX_RELAY]    = slc_pkg::MODE_SOLID;
    assign fault_mode[slc_pkg::PIX_BRIDGE]   = slc_pkg::MODE_BLINK;
    assign fault_mode[slc_pkg::PIX_NETWORK]  = slc_pkg::MODE_BLINK;
    assign fault_color[slc_pkg::PIX_MEMORY]  = slc_pkg::COL_RED;
    assign fault_color[slc_pkg::PIX_SENSORS] = slc_pkg::COL_RED;
    assign fault_color[slc_pkg::PIX_RELAY]   = slc_pkg::COL_RED;
    assign fault_color[slc_pkg::PIX_BRIDGE]  = slc_pkg::COL_RED;
    assign fault_color[slc_pkg::PIX_NETWORK] = slc_pkg::COL_YELLOW;

    always_comb begin
        mode_next        = mode_reg;
        color_next       = color_reg;
        phase_next       = phase_reg;
        blink_time_next  = blink_time_reg;
        pulse_next       = pulse_reg;
        pulse_time_next  = pulse_time_reg;
        mem_color_next   = mem_color_reg;
        burst_rem_next   = burst_rem_reg;
        burst_lit_next   = burst_lit_reg;
        burst_time_next  = burst_time_reg;
        prev_status_next = prev_status_reg;
        refresh          = 1'b0;
        burst_sum        = '0;
        hold             = '0;
        any_blink        = 1'b0;
        new_mode         = slc_pkg::MODE_OFF;
        new_color        = '0;
        push_frame       = '0;
        push_frame.count = frame_len;
        if (accept && in_item.clear_all) begin
            mode_next      = '0;
            color_next     = '0;
            pulse_next     = '0;
            burst_rem_next = '0;
            burst_lit_next = 1'b0;
            refresh        = 1'b1;
        end else if (accept) begin
            if (in_item.trigger_bridge) begin
                pulse_time_next[0] = in_item.now_ms;
                pulse_next[0]      = 1'b1;
                refresh            = 1'b1;
            end
            if (in_item.trigger_network) begin
                pulse_time_next[1] = in_item.now_ms;
                pulse_next[1]      = 1'b1;
                refresh            = 1'b1;
            end
            if (in_item.trigger_memory) begin
                mem_color_next     = in_item.memory_color;
                pulse_time_next[2] = in_item.now_ms;
                pulse_next[2]      = 1'b1;
                refresh            = 1'b1;
            end
            if (in_item.burst_add != 8'd0) begin
                burst_sum      = {1'b0, burst_rem_reg} + {1'b0, in_item.burst_add};
                burst_rem_next = burst_sum[8] ? 8'hFF : burst_sum[7:0];
                if (!burst_lit_reg) begin
                    burst_lit_next  = 1'b1;
                    burst_time_next = in_item.now_ms;
                    refresh         = 1'b1;
                end
            end
            if (in_item.status_word != prev_status_reg) begin
                prev_status_next = in_item.status_word;
                for (int k = 0; k < slc_pkg::STATUS_PIX; k++) begin
                    new_mode  = ok[k] ? slc_pkg::MODE_OFF : fault_mode[k];
                    new_color = ok[k] ? 24'd0 : fault_color[k];
                    if (3'(k) < pixel_count_reg &&
                        (mode_next[k] != new_mode || color_next[k] != new_color)) begin
                        mode_next[k]  = new_mode;
                        color_next[k] = new_color;
                        refresh       = 1'b1;
                    end
                end
            end
            if ((in_item.now_ms - blink_time_reg) >= {16'd0, blink_half_reg}) begin
                blink_time_next = in_item.now_ms;
                phase_next      = !phase_reg;
                for (int k = 0; k < slc_pkg::PIXELS; k++) begin
                    if (mode_next[k] == slc_pkg::MODE_BLINK) begin
                        any_blink = 1'b1;
                    end
                end
                if (any_blink) begin
                    refresh = 1'b1;
                end
            end
            for (int p = 0; p < 3; p++) begin
                hold = (p == 2) ? {16'd0, memory_hold_reg} : {16'd0, traffic_hold_reg};
                if (pulse_next[p] && (in_item.now_ms - pulse_time_next[p]) >= hold) begin
                    pulse_next[p] = 1'b0;
                    refresh       = 1'b1;
                end
            end
            if (burst_rem_next != 8'd0 || burst_lit_next) begin
                if ((in_item.now_ms - burst_time_next) >= {16'd0, burst_half_reg}) begin
                    burst_time_next = in_item.now_ms;
                    if (burst_lit_next) begin
                        burst_lit_next = 1'b0;
                        if (burst_rem_next != 8'd0) begin
                            burst_rem_next = burst_rem_next - 8'd1;
                        end
                    end else begin
                        burst_lit_next = 1'b1;
                    end
                    refresh = 1'b1;
                end
            end
            for (int k = 0; k < slc_pkg::PIXELS; k++) begin
                if (mode_next[k] == slc_pkg::MODE_SOLID ||
                    (mode_next[k] == slc_pkg::MODE_BLINK && phase_next)) begin
                    push_frame.colors[k] = color_next[k];
                end
            end
            if (pulse_next[0]) begin
                push_frame.colors[slc_pkg::PIX_BRIDGE] = slc_pkg::COL_WHITE;
            end
            if (pulse_next[1]) begin
                push_frame.colors[slc_pkg::PIX_NETWORK] = slc_pkg::COL_YELLOW;
            end
            if (pulse_next[2]) begin
                push_frame.colors[slc_pkg::PIX_MEMORY] = mem_color_next;
            end
            push_frame.colors[slc_pkg::PIX_ACTIVITY] = burst_lit_next ? slc_pkg::COL_BLUE : 24'd0;
            push_frame.act = (burst_rem_next != 8'd0) || burst_lit_next;
        end
    end

    assign push = refresh && (frame_len != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg  <= 3'd6;
            blink_half_reg   <= 16'd500;
            burst_half_reg   <= 16'd100;
            traffic_hold_reg <= 16'd50;
            memory_hold_reg  <= 16'd200;
            mode_reg         <= '0;
            color_reg        <= '0;
            phase_reg        <= 1'b0;
            blink_time_reg   <= '0;
            pulse_reg        <= '0;
            pulse_time_reg   <= '0;
            mem_color_reg    <= '0;
            burst_rem_reg    <= '0;
            burst_lit_reg    <= 1'b0;
            burst_time_reg   <= '0;
            prev_status_reg  <= '0;
        end else begin
            mode_reg        <= mode_next;
            color_reg       <= color_next;
            phase_reg       <= phase_next;
            blink_time_reg  <= blink_time_next;
            pulse_reg       <= pulse_next;
            pulse_time_reg  <= pulse_time_next;
            mem_color_reg   <= mem_color_next;
            burst_rem_reg   <= burst_rem_next;
            burst_lit_reg   <= burst_lit_next;
            burst_time_reg  <= burst_time_next;
            prev_status_reg <= prev_status_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    slc_pkg::CFG_PIXEL_COUNT:  pixel_count_reg  <= cfg_wdata[2:0];
                    slc_pkg::CFG_BLINK_HALF:   blink_half_reg   <= cfg_wdata;
                    slc_pkg::CFG_BURST_HALF:   burst_half_reg   <= cfg_wdata;
                    slc_pkg::CFG_TRAFFIC_HOLD: traffic_hold_reg <= cfg_wdata;
                    slc_pkg::CFG_MEMORY_HOLD:  memory_hold_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/slc_queue.sv @@
// Short frame queue between the front and back parts.
module slc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  slc_pkg::frame_t push_frame,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output slc_pkg::frame_t pop_frame
);

    localparam int PTR_W = $clog2(slc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(slc_pkg::QUEUE_DEPTH + 1);

    slc_pkg::frame_t slot_reg [slc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(slc_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_frame = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(slc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(slc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/slc_back.sv @@
// Back part: plays one queued frame out as one pixel transfer per cycle while the output is ready.
module slc_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       frame_valid,
    input  slc_pkg::frame_t            frame,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 out_index,
    output logic [23:0]                out_color,
    output logic                       out_last,
    output logic                       out_act
);

    slc_pkg::frame_t           cur_reg;
    logic                      busy_reg;
    logic [slc_pkg::IDX_W-1:0] idx_reg;
    logic                      valid_reg;
    logic [2:0]                index_reg;
    logic [23:0]               color_reg;
    logic                      last_reg;
    logic                      act_reg;
    logic                      advance;
    logic                      is_last;

    assign pop     = !busy_reg && frame_valid;
    assign advance = busy_reg && (!valid_reg || out_ready);
    assign is_last = ({1'b0, idx_reg} + (slc_pkg::IDX_W + 1)'(1))
                     == (slc_pkg::IDX_W + 1)'(cur_reg.count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (pop) begin
                cur_reg  <= frame;
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            if (advance) begin
                valid_reg <= 1'b1;
                index_reg <= 3'(idx_reg);
                color_reg <= cur_reg.colors[idx_reg];
                last_reg  <= is_last;
                act_reg   <= cur_reg.act;
                idx_reg   <= idx_reg + slc_pkg::IDX_W'(1);
                if (is_last) begin
                    busy_reg <= 1'b0;
                end
            end else if (valid_reg && out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_color = color_reg;
    assign out_last  = last_reg;
    assign out_act   = act_reg;

endmodule

@@ hw/rtl/status_led_blink_controller.sv @@
// Top level of the status LED blink controller.
// The front part takes one pass per cycle while the frame queue has room.
// A pass's frame goes into a queue slot, then the back part's frame register, then
// its output register; the next frame is taken after the last pixel is registered.
// Synchronous active-low reset restores the register defaults and clears all
// pixel, pulse, burst and queue state.
module status_led_blink_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms, status_word, trigger_bridge, trigger_network, trigger_memory,
    // memory_color, burst_add, clear_all, zero fill
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_index, pixel_color, burst_active, zero fill
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    slc_pkg::in_item_t in_item;
    slc_pkg::frame_t   push_frame, pop_frame;
    logic              push, full, pop, pop_valid;
    logic [2:0]        pixel_index;
    logic [23:0]       pixel_color;
    logic              burst_active;

    assign in_item = slc_pkg::in_item_t'(s_tdata[75:0]);

    slc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .push_frame (push_frame),
        .queue_full (full)
    );

    slc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .full       (full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_frame  (pop_frame)
    );

    slc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (pop_valid),
        .frame       (pop_frame),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_index   (pixel_index),
        .out_color   (pixel_color),
        .out_last    (m_tlast),
        .out_act     (burst_active)
    );

    assign m_tdata = {4'd0, burst_active, pixel_color, pixel_index};

endmodule

@@ hw/rtl/slc_checker.sv @@
// Port-level assertions for the status LED blink controller and their binding.
module slc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result changed.");

    a_frame_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid
            && m_tdata[2:0] == 3'($past(m_tdata[2:0]) + 3'd1))
        else $error("Frame did not continue with the next pixel.");

    a_burst_flag_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tdata[27] == $past(m_tdata[27]))
        else $error("Burst flag changed inside a frame.");

    a_first_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast && $past(!m_tvalid) |-> m_tdata[2:0] == 3'd0)
        else $error("Single-pixel frame does not start at pixel zero.");

endmodule

bind status_led_blink_controller slc_checker u_checker (.*);

@@ tb/status_led_frame_checker.sv @@
// Checker that predicts the pixel frames of the status LED controller and compares each transfer.
module status_led_frame_checker
    import slc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [2:0]  pix;
        logic [23:0] color;
        logic        last;
        logic        active;
    } pixel_xfer_t;

    pixel_xfer_t expected_pixels[$];

    logic [2:0]  pixel_count_q;
    logic [15:0] blink_half_q;
    logic [15:0] burst_half_q;
    logic [15:0] traffic_hold_q;
    logic [15:0] memory_hold_q;

    logic [1:0]  mode_q [PIXELS];
    logic [23:0] color_q [PIXELS];
    logic        blink_phase_q;
    logic [31:0] blink_stamp;
    logic        pulse_on [3];
    logic [31:0] pulse_stamp [3];
    logic [23:0] memory_hue;
    logic [7:0]  blinks_left;
    logic        blue_lit;
    logic [31:0] blue_stamp;
    logic [7:0]  prev_status_q;
    logic        dirty;

    task automatic map_pixel(input int p, input bit ok, input logic [1:0] mode,
                             input logic [23:0] hue);
        logic [1:0]  m;
        logic [23:0] c;
        m = ok ? MODE_OFF : mode;
        c = ok ? 24'h000000 : hue;
        if (p < int'(pixel_count_q) && p < PIXELS) begin
            if (mode_q[p] != m || color_q[p] != c) begin
                mode_q[p]  = m;
                color_q[p] = c;
                dirty      = 1'b1;
            end
        end
    endtask

    task automatic queue_frame(input logic [PIXELS-1:0][23:0] hues);
        int          n;
        logic        act;
        pixel_xfer_t x;
        n   = (int'(pixel_count_q) < PIXELS) ? int'(pixel_count_q) : PIXELS;
        act = (blinks_left != 8'd0) || blue_lit;
        for (int i = 0; i < n; i++) begin
            x.pix    = 3'(i);
            x.color  = hues[i];
            x.last   = (i + 1 == n);
            x.active = act;
            expected_pixels.push_back(x);
        end
    endtask

    task automatic predict_frame(input in_item_t it);
        logic [PIXELS-1:0][23:0] hues;
        logic [8:0]              sum;
        logic [15:0]             hold;
        hues = '0;
        if (it.clear_all) begin
            for (int i = 0; i < PIXELS; i++) begin
                mode_q[i]  = MODE_OFF;
                color_q[i] = 24'h000000;
            end
            for (int i = 0; i < 3; i++) pulse_on[i] = 1'b0;
            blinks_left = 8'd0;
            blue_lit    = 1'b0;
            dirty       = 1'b0;
            queue_frame(hues);
            return;
        end
        if (it.trigger_bridge) begin
            pulse_stamp[0] = it.now_ms;
            pulse_on[0]    = 1'b1;
            dirty          = 1'b1;
        end
        if (it.trigger_network) begin
            pulse_stamp[1] = it.now_ms;
            pulse_on[1]    = 1'b1;
            dirty          = 1'b1;
        end
        if (it.trigger_memory) begin
            memory_hue     = it.memory_color;
            pulse_stamp[2] = it.now_ms;
            pulse_on[2]    = 1'b1;
            dirty          = 1'b1;
        end
        if (it.burst_add != 8'd0) begin
            sum         = {1'b0, blinks_left} + {1'b0, it.burst_add};
            blinks_left = sum[8] ? 8'hFF : sum[7:0];
            if (!blue_lit) begin
                blue_lit   = 1'b1;
                blue_stamp = it.now_ms;
                dirty      = 1'b1;
            end
        end
        if (it.status_word != prev_status_q) begin
            prev_status_q = it.status_word;
            map_pixel(PIX_MEMORY, it.status_word[1:0] == 2'b11, MODE_SOLID, COL_RED);
            map_pixel(PIX_SENSORS, it.status_word[3:2] == 2'b11, MODE_BLINK, COL_RED);
            map_pixel(PIX_RELAY, it.status_word[6], MODE_SOLID, COL_RED);
            map_pixel(PIX_BRIDGE, it.status_word[7], MODE_BLINK, COL_RED);
            map_pixel(PIX_NETWORK, it.status_word[5:4] == 2'b11, MODE_BLINK, COL_YELLOW);
        end
        if (32'(it.now_ms - blink_stamp) >= {16'd0, blink_half_q}) begin
            blink_stamp   = it.now_ms;
            blink_phase_q = !blink_phase_q;
            for (int i = 0; i < PIXELS; i++)
                if (mode_q[i] == MODE_BLINK) dirty = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            hold = (i == 2) ? memory_hold_q : traffic_hold_q;
            if (pulse_on[i] && 32'(it.now_ms - pulse_stamp[i]) >= {16'd0, hold}) begin
                pulse_on[i] = 1'b0;
                dirty       = 1'b1;
            end
        end
        if (blinks_left != 8'd0 || blue_lit) begin
            if (32'(it.now_ms - blue_stamp) >= {16'd0, burst_half_q}) begin
                blue_stamp = it.now_ms;
                if (blue_lit) begin
                    blue_lit = 1'b0;
                    if (blinks_left != 8'd0) blinks_left = blinks_left - 8'd1;
                end else if (blinks_left != 8'd0) begin
                    blue_lit = 1'b1;
                end
                dirty = 1'b1;
            end
        end
        if (!dirty) return;
        dirty = 1'b0;
        for (int i = 0; i < PIXELS; i++) begin
            if (mode_q[i] == MODE_SOLID || (mode_q[i] == MODE_BLINK && blink_phase_q))
                hues[i] = color_q[i];
        end
        if (pulse_on[0]) hues[PIX_BRIDGE] = COL_WHITE;
        if (pulse_on[1]) hues[PIX_NETWORK] = COL_YELLOW;
        if (pulse_on[2]) hues[PIX_MEMORY] = memory_hue;
        hues[PIX_ACTIVITY] = blue_lit ? COL_BLUE : 24'h000000;
        queue_frame(hues);
    endtask

    always @(posedge aclk) begin
        pixel_xfer_t want;
        if (!aresetn) begin
            pixel_count_q  = 3'd6;
            blink_half_q   = 16'd500;
            burst_half_q   = 16'd100;
            traffic_hold_q = 16'd50;
            memory_hold_q  = 16'd200;
            for (int i = 0; i < PIXELS; i++) begin
                mode_q[i]  = MODE_OFF;
                color_q[i] = 24'h000000;
            end
            for (int i = 0; i < 3; i++) begin
                pulse_on[i]    = 1'b0;
                pulse_stamp[i] = 32'd0;
            end
            blink_phase_q = 1'b0;
            blink_stamp   = 32'd0;
            memory_hue    = 24'h000000;
            blinks_left   = 8'd0;
            blue_lit      = 1'b0;
            blue_stamp    = 32'd0;
            prev_status_q = 8'd0;
            dirty         = 1'b0;
            expected_pixels.delete();
            fail_count  = 0;
            checked     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel transfer: index %0d color %h",
                           m_tdata[2:0], m_tdata[26:3]);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (m_tdata[2:0] != want.pix) begin
                        $error("pixel_index expected %0d got %0d", want.pix, m_tdata[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[26:3] != want.color) begin
                        $error("pixel_color expected %h got %h", want.color, m_tdata[26:3]);
                        fail_count++;
                    end
                    if (m_tlast != want.last) begin
                        $error("frame_last expected %0b got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[27] != want.active) begin
                        $error("burst_active expected %0b got %0b", want.active, m_tdata[27]);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PIXEL_COUNT:  pixel_count_q  = cfg_wdata[2:0];
                    CFG_BLINK_HALF:   blink_half_q   = cfg_wdata;
                    CFG_BURST_HALF:   burst_half_q   = cfg_wdata;
                    CFG_TRAFFIC_HOLD: traffic_hold_q = cfg_wdata;
                    CFG_MEMORY_HOLD:  memory_hold_q  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_frame(s_tdata[$bits(in_item_t)-1:0]);
        end
        pending = expected_pixels.size();
    end

endmodule

@@ tb/status_led_blink_controller_tb.sv @@
// Testbench top that drives service passes and register settings into the LED controller.
module status_led_blink_controller_tb;
    import slc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int NUM_SETTINGS  = 7;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int passes_sent = 0;
    int tx_idle_pct = 13;
    int rx_idle_pct = 68;

    int setting_pixels [NUM_SETTINGS] = '{6, 4, 0, 1, 6, 5, 6};
    int setting_period [NUM_SETTINGS] = '{3, 1, 5, 2, 65535, 0, 10};
    int setting_passes [NUM_SETTINGS] = '{40, 35, 10, 20, 30, 30, 65};
    int setting_step   [NUM_SETTINGS] = '{10, 3, 8, 5, 140000, 4, 40};

    logic [31:0] clock_ms;
    logic [7:0]  status;

    status_led_blink_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    status_led_frame_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_pass(input logic [31:0] now_ms, input logic [7:0] status_word,
                             input logic [2:0] triggers, input logic [23:0] hue,
                             input logic [7:0] add, input logic clear);
        in_item_t    it;
        logic [79:0] word;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        it.now_ms          = now_ms;
        it.status_word     = status_word;
        it.trigger_bridge  = triggers[0];
        it.trigger_network = triggers[1];
        it.trigger_memory  = triggers[2];
        it.memory_color    = hue;
        it.burst_add       = add;
        it.clear_all       = clear;
        word = '0;
        word[$bits(in_item_t)-1:0] = it;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        passes_sent++;
    endtask

    task automatic hold_until_drained(input int extra);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
    endtask

    initial begin
        int          r;
        logic [15:0] blink_v, burst_v, traffic_v, memory_v;
        logic [2:0]  triggers;
        logic [7:0]  add;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_PIXEL_COUNT;
        cfg_wdata = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_pass(32'd0, 8'h00, 3'b000, 24'h000000, 8'd0, 1'b0);
        send_pass(32'd10, 8'hFF, 3'b000, 24'h000000, 8'd0, 1'b0);
        send_pass(32'd20, 8'h00, 3'b000, 24'h000000, 8'd0, 1'b0);
        send_pass(32'd30, 8'h00, 3'b001, 24'h000000, 8'd0, 1'b0);
        send_pass(32'd35, 8'h00, 3'b010, 24'h000000, 8'd0, 1'b0);
        send_pass(32'd40, 8'h00, 3'b100, 24'hFFFFFF, 8'd0, 1'b0);
        send_pass(32'd41, 8'h00, 3'b100, 24'h000000, 8'd0, 1'b0);
        send_pass(32'd45, 8'h00, 3'b000, 24'h000000, 8'hFF, 1'b0);
        send_pass(32'd46, 8'h00, 3'b000, 24'h000000, 8'd1, 1'b0);
        send_pass(32'd100, 8'h5A, 3'b000, 24'h000000, 8'd0, 1'b0);
        send_pass(32'd600, 8'hA5, 3'b000, 24'h000000, 8'd0, 1'b0);
        send_pass(32'd601, 8'hFF, 3'b111, 24'h5A5A5A, 8'hAA, 1'b1);
        send_pass(32'hFFFF_FF00, 8'h3C, 3'b001, 24'h000000, 8'd0, 1'b0);
        send_pass(32'h0000_0010, 8'hC3, 3'b010, 24'h000000, 8'd3, 1'b0);
        send_pass(32'hFFFF_FFFF, 8'h00, 3'b100, 24'hA5A5A5, 8'h55, 1'b0);
        send_pass(32'h8000_0000, 8'h40, 3'b000, 24'h000000, 8'd0, 1'b0);
        send_pass(32'h8000_0001, 8'h80, 3'b000, 24'h000000, 8'd0, 1'b1);
        send_pass(32'h8000_0200, 8'h30, 3'b111, 24'h0F0F0F, 8'd2, 1'b0);

        clock_ms = 32'hFFFF_FE00;
        status   = 8'hFF;
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            hold_until_drained(SETTLE_CYCLES);
            blink_v   = 16'(setting_period[p]);
            burst_v   = 16'(setting_period[p]);
            traffic_v = 16'(setting_period[p]);
            memory_v  = 16'(setting_period[p]);
            if (p == 0) begin
                burst_v   = 16'd2;
                traffic_v = 16'd4;
                memory_v  = 16'd7;
            end else if (p == NUM_SETTINGS - 1) begin
                setting_pixels[p] = $urandom_range(1, 6);
                blink_v   = 16'($urandom_range(1, 20));
                burst_v   = 16'($urandom_range(1, 20));
                traffic_v = 16'($urandom_range(1, 20));
                memory_v  = 16'($urandom_range(1, 20));
            end
            cfg_write(CFG_PIXEL_COUNT, 16'(setting_pixels[p]));
            cfg_write(CFG_BLINK_HALF, blink_v);
            cfg_write(CFG_BURST_HALF, burst_v);
            cfg_write(CFG_TRAFFIC_HOLD, traffic_v);
            cfg_write(CFG_MEMORY_HOLD, memory_v);
            cfg_wr_en <= 1'b0;
            if (p < 2) begin
                tx_idle_pct = 13;
                rx_idle_pct = 68;
            end else if (p < 5) begin
                tx_idle_pct = 68;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int k = 0; k < setting_passes[p]; k++) begin
                if (k == setting_passes[p] / 2 && (p == 0 || p == 4 || p == 6))
                    hold_until_drained(0);
                if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
                else clock_ms = clock_ms + $urandom_range(0, setting_step[p]);
                r = $urandom_range(0, 3);
                if (r == 0) status = 8'($urandom_range(0, 255));
                else if (r == 1) status = 8'hFF ^ (8'd1 << $urandom_range(0, 7));
                triggers = {$urandom_range(0, 99) < 20, $urandom_range(0, 99) < 20,
                            $urandom_range(0, 99) < 20};
                r = $urandom_range(0, 99);
                if (r < 70) add = 8'd0;
                else if (r < 90) add = 8'($urandom_range(1, 3));
                else add = 8'($urandom_range(0, 255));
                send_pass(clock_ms, status, triggers, 24'($urandom_range(0, 24'hFFFFFF)),
                          add, $urandom_range(0, 99) < 3);
            end
        end

        hold_until_drained(SETTLE_CYCLES);
        $display("Sent %0d service passes under %0d register settings and idle patterns.",
                 passes_sent, NUM_SETTINGS + 1);
        $display("Checked %0d pixel transfers against the predicted frames.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
